// ===== hdl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared codes and types of the banker's safety check engine: operation and
// status codes, configuration register indexes and the flag bundle that the
// arithmetic unit returns to the sequencer.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam logic [2:0] OP_WR_ALLOC = 3'd0;
  localparam logic [2:0] OP_WR_MAX   = 3'd1;
  localparam logic [2:0] OP_WR_AVAIL = 3'd2;
  localparam logic [2:0] OP_CHECK    = 3'd3;
  localparam logic [2:0] OP_REQ_ELEM = 3'd4;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_SAFE      = 3'd1;
  localparam logic [2:0] ST_UNSAFE    = 3'd2;
  localparam logic [2:0] ST_GRANTED   = 3'd3;
  localparam logic [2:0] ST_OVER_NEED = 3'd4;
  localparam logic [2:0] ST_OVER_AVL  = 3'd5;
  localparam logic [2:0] ST_DENIED    = 3'd6;

  localparam logic CFG_PROC_COUNT = 1'b0;
  localparam logic CFG_RES_COUNT  = 1'b1;

  localparam int CFG_DATA_W = 5;

  typedef struct packed {
    logic need_gt_x;  // need exceeds the compared operand
    logic x_gt_need;  // compared operand exceeds need
  } alu_flags_t;

endpackage

// ===== hdl/bsc_table.sv =====
// ----------------------------------------------------------------------------
// bsc_table
// One count table: single write port, single registered read port. Each
// entry has a valid bit cleared by reset; an entry never written reads zero.
// ----------------------------------------------------------------------------
module bsc_table #(
  parameter int DEPTH  = 128,
  parameter int DATA_W = 8,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DATA_W-1:0] rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ===== hdl/bsc_alu.sv =====
// ----------------------------------------------------------------------------
// bsc_alu
// Shared arithmetic unit: need (maximum minus allocation, floored at zero)
// compared against one operand, and a saturating add.
// ----------------------------------------------------------------------------
module bsc_alu #(
  parameter int COUNT_BITS = 8
) (
  input  logic [COUNT_BITS-1:0] max_val,
  input  logic [COUNT_BITS-1:0] alloc_val,
  input  logic [COUNT_BITS-1:0] cmp_val,
  input  logic [COUNT_BITS-1:0] add_a,
  input  logic [COUNT_BITS-1:0] add_b,
  output bsc_pkg::alu_flags_t   flags,
  output logic [COUNT_BITS-1:0] sum_sat
);

  logic [COUNT_BITS-1:0] need;
  logic [COUNT_BITS:0]   sum;

  assign need            = (max_val > alloc_val) ? (max_val - alloc_val) : '0;
  assign flags.need_gt_x = need > cmp_val;
  assign flags.x_gt_need = cmp_val > need;

  assign sum     = {1'b0, add_a} + {1'b0, add_b};
  assign sum_sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

endmodule

// ===== hdl/bankers_safety_check.sv =====
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm engine: allocation and maximum tables, available vector,
// request evaluation with tentative grant and roll-back, and safety check.
//
//   channel   ports                                        transfer
//   input     start, busy, in_opcode .. in_last_element    start & !busy
//   result    out_valid, out_status, out_proc_echo         out_valid
//   config    cfg_we, cfg_index, cfg_data                  cfg_we
//
// Writes answer in the cycle after the transfer; a request element that is not
// the last gives no answer. A safety check scans one table element per cycle
// through the shared unit: an unfinished process is judged in S_PSEL and S_FIT
// and its allocation is added to work in S_ADD; a finished process is skipped
// in S_PSEL. Worst case each pass finishes one process. A request passes
// S_REQ, S_RCHK and S_APPLY before its check, and S_ROLL to roll back.
// busy is high throughout. Reset is synchronous; tables read zero until
// written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module bankers_safety_check #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_opcode,
  input  logic [3:0] in_proc_index,
  input  logic [2:0] in_res_index,
  input  logic [7:0] in_amount,
  input  logic       in_last_element,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [3:0] out_proc_echo,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PW    = $clog2(MAX_PROCS + 1);
  localparam int RW    = $clog2(MAX_RES + 1);
  localparam logic [16:0] CMAX = (17'd1 << COUNT_BITS) - 17'd1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PSEL  = 3'd1;
  localparam logic [2:0] S_FIT   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_REQ   = 3'd4;
  localparam logic [2:0] S_RCHK  = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_ROLL  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [4:0]            proc_count_r;
  logic [3:0]            res_count_r;
  logic [PIW-1:0]        p_r, p_nxt;
  logic [RW-1:0]         ra_r, ra_nxt;
  logic [RIW-1:0]        rd_r, rd_nxt;
  logic                  pend_r, pend_nxt;
  logic                  flag_r, flag_nxt;
  logic                  progress_r, progress_nxt;
  logic                  req_mode_r, req_mode_nxt;
  logic [3:0]            reqp_r, reqp_nxt;
  logic [MAX_PROCS-1:0]  fin_r, fin_nxt;
  logic [COUNT_BITS-1:0] work_r  [MAX_RES];
  logic [COUNT_BITS-1:0] work_nxt[MAX_RES];
  logic [COUNT_BITS-1:0] avail_r [MAX_RES];
  logic [COUNT_BITS-1:0] avail_nxt[MAX_RES];
  logic [COUNT_BITS-1:0] req_r   [MAX_RES];
  logic [COUNT_BITS-1:0] req_nxt [MAX_RES];
  logic [COUNT_BITS-1:0] row_r   [MAX_RES];
  logic [COUNT_BITS-1:0] row_nxt [MAX_RES];
  logic [COUNT_BITS-1:0] keep_r  [MAX_RES];
  logic [COUNT_BITS-1:0] keep_nxt[MAX_RES];
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [3:0]            out_echo_r, out_echo_nxt;

  logic [PW-1:0]         np;
  logic [RW-1:0]         nr;
  logic [MAX_PROCS-1:0]  proc_mask;
  logic [RIW-1:0]        ra_i;
  logic [COUNT_BITS-1:0] amt_c;
  logic                  accept;
  logic                  in_p_ok, in_r_ok;
  logic [AW-1:0]         in_addr, rd_addr, req_addr;
  logic                  over_avail;
  logic                  adv, start_chk, last_rd, last_ra;

  logic                  alloc_we, max_we;
  logic [AW-1:0]         alloc_waddr;
  logic [COUNT_BITS-1:0] alloc_wdata;
  logic [COUNT_BITS-1:0] alloc_rd, max_rd;
  logic [COUNT_BITS-1:0] cmp_val, add_a, add_b, sum_sat;
  bsc_pkg::alu_flags_t   flags;

  // Effective counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (proc_count_r == 5'd0) begin
      np = PW'(1);
    end else if (32'(proc_count_r) > MAX_PROCS) begin
      np = PW'(MAX_PROCS);
    end else begin
      np = PW'(proc_count_r);
    end
    if (res_count_r == 4'd0) begin
      nr = RW'(1);
    end else if (32'(res_count_r) > MAX_RES) begin
      nr = RW'(MAX_RES);
    end else begin
      nr = RW'(res_count_r);
    end
    for (int i = 0; i < MAX_PROCS; i++) begin
      proc_mask[i] = 32'(i) < 32'(np);
    end
  end

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = state_r != S_IDLE;
  assign ra_i     = ra_r[RIW-1:0];
  assign in_p_ok  = 32'(in_proc_index) < MAX_PROCS;
  assign in_r_ok  = 32'(in_res_index) < MAX_RES;
  assign amt_c    = (17'(in_amount) > CMAX) ? CMAX[COUNT_BITS-1:0]
                                            : COUNT_BITS'(in_amount);
  assign in_addr  = AW'(32'(in_proc_index) * MAX_RES + 32'(in_res_index));
  assign rd_addr  = AW'(32'(p_r) * MAX_RES + 32'(ra_r));
  assign req_addr = AW'(32'(reqp_r) * MAX_RES + 32'(ra_r));
  assign last_rd  = RW'(rd_r) == (nr - RW'(1));
  assign last_ra  = ra_r == (nr - RW'(1));

  always_comb begin
    over_avail = 1'b0;
    for (int r = 0; r < MAX_RES; r++) begin
      if (32'(r) < 32'(nr) && req_r[r] > avail_r[r]) begin
        over_avail = 1'b1;
      end
    end
  end

  // Table ports
  assign max_we = accept && (in_opcode == bsc_pkg::OP_WR_MAX) && in_p_ok && in_r_ok;

  always_comb begin
    alloc_we    = 1'b0;
    alloc_waddr = in_addr;
    alloc_wdata = amt_c;
    case (state_r)
      S_IDLE: begin
        alloc_we = accept && (in_opcode == bsc_pkg::OP_WR_ALLOC) && in_p_ok && in_r_ok;
      end
      S_APPLY: begin
        alloc_we    = 1'b1;
        alloc_waddr = req_addr;
        alloc_wdata = sum_sat;
      end
      S_ROLL: begin
        alloc_we    = 1'b1;
        alloc_waddr = req_addr;
        alloc_wdata = keep_r[ra_i];
      end
      default: begin
        alloc_we = 1'b0;
      end
    endcase
  end

  bsc_table #(.DEPTH(DEPTH), .DATA_W(COUNT_BITS), .ADDR_W(AW)) u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wdata (alloc_wdata),
    .raddr ((state_r == S_RCHK) ? req_addr : rd_addr),
    .rdata (alloc_rd)
  );

  bsc_table #(.DEPTH(DEPTH), .DATA_W(COUNT_BITS), .ADDR_W(AW)) u_max (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (max_we),
    .waddr (in_addr),
    .wdata (amt_c),
    .raddr ((state_r == S_RCHK) ? req_addr : rd_addr),
    .rdata (max_rd)
  );

  // Shared unit operands
  assign cmp_val = (state_r == S_FIT) ? work_r[rd_r] : req_r[rd_r];
  assign add_a   = (state_r == S_ADD) ? work_r[ra_i] : keep_r[ra_i];
  assign add_b   = (state_r == S_ADD) ? row_r[ra_i]  : req_r[ra_i];

  bsc_alu #(.COUNT_BITS(COUNT_BITS)) u_alu (
    .max_val   (max_rd),
    .alloc_val (alloc_rd),
    .cmp_val   (cmp_val),
    .add_a     (add_a),
    .add_b     (add_b),
    .flags     (flags),
    .sum_sat   (sum_sat)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    ra_nxt         = ra_r;
    rd_nxt         = rd_r;
    pend_nxt       = 1'b0;
    flag_nxt       = flag_r;
    progress_nxt   = progress_r;
    req_mode_nxt   = req_mode_r;
    reqp_nxt       = reqp_r;
    fin_nxt        = fin_r;
    work_nxt       = work_r;
    avail_nxt      = avail_r;
    req_nxt        = req_r;
    row_nxt        = row_r;
    keep_nxt       = keep_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_echo_nxt   = out_echo_r;
    adv            = 1'b0;
    start_chk      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_echo_nxt = in_proc_index;
          case (in_opcode)
            bsc_pkg::OP_WR_ALLOC, bsc_pkg::OP_WR_MAX: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = bsc_pkg::ST_WRITTEN;
            end
            bsc_pkg::OP_WR_AVAIL: begin
              if (in_r_ok) begin
                avail_nxt[RIW'(in_res_index)] = amt_c;
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = bsc_pkg::ST_WRITTEN;
            end
            bsc_pkg::OP_CHECK: begin
              req_mode_nxt = 1'b0;
              start_chk    = 1'b1;
            end
            bsc_pkg::OP_REQ_ELEM: begin
              if (in_r_ok) begin
                req_nxt[RIW'(in_res_index)] = amt_c;
              end
              if (in_last_element) begin
                reqp_nxt  = in_proc_index;
                state_nxt = S_REQ;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end

      S_PSEL: begin
        if (fin_r[p_r]) begin
          adv = 1'b1;
        end else begin
          ra_nxt    = '0;
          flag_nxt  = 1'b1;
          state_nxt = S_FIT;
        end
      end

      // Issue one read per cycle; judge the element read in the cycle before
      S_FIT: begin
        if (ra_r < nr) begin
          pend_nxt = 1'b1;
          rd_nxt   = ra_i;
          ra_nxt   = ra_r + RW'(1);
        end
        if (pend_r) begin
          row_nxt[rd_r] = alloc_rd;
          if (flags.need_gt_x) begin
            flag_nxt = 1'b0;
          end
          if (last_rd) begin
            pend_nxt = 1'b0;
            if (flag_r && !flags.need_gt_x) begin
              ra_nxt    = '0;
              state_nxt = S_ADD;
            end else begin
              adv = 1'b1;
            end
          end
        end
      end

      S_ADD: begin
        work_nxt[ra_i] = sum_sat;
        ra_nxt         = ra_r + RW'(1);
        if (last_ra) begin
          fin_nxt[p_r] = 1'b1;
          progress_nxt = 1'b1;
          adv          = 1'b1;
        end
      end

      S_REQ: begin
        if (32'(reqp_r) >= 32'(np)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bsc_pkg::ST_OVER_NEED;
          for (int r = 0; r < MAX_RES; r++) req_nxt[r] = '0;
          state_nxt = S_IDLE;
        end else begin
          ra_nxt    = '0;
          flag_nxt  = 1'b0;
          state_nxt = S_RCHK;
        end
      end

      S_RCHK: begin
        if (ra_r < nr) begin
          pend_nxt = 1'b1;
          rd_nxt   = ra_i;
          ra_nxt   = ra_r + RW'(1);
        end
        if (pend_r) begin
          keep_nxt[rd_r] = alloc_rd;
          if (flags.x_gt_need) begin
            flag_nxt = 1'b1;
          end
          if (last_rd) begin
            pend_nxt = 1'b0;
            ra_nxt   = '0;
            if (flag_r || flags.x_gt_need || over_avail) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (flag_r || flags.x_gt_need) ? bsc_pkg::ST_OVER_NEED
                                                           : bsc_pkg::ST_OVER_AVL;
              for (int r = 0; r < MAX_RES; r++) req_nxt[r] = '0;
              state_nxt = S_IDLE;
            end else begin
              for (int r = 0; r < MAX_RES; r++) begin
                if (32'(r) < 32'(nr)) avail_nxt[r] = avail_r[r] - req_r[r];
              end
              state_nxt = S_APPLY;
            end
          end
        end
      end

      // Tentative grant: allocation plus request, one element per cycle
      S_APPLY: begin
        ra_nxt = ra_r + RW'(1);
        if (last_ra) begin
          req_mode_nxt = 1'b1;
          start_chk    = 1'b1;
        end
      end

      // Unsafe: restore the saved allocation row and hand units back
      S_ROLL: begin
        ra_nxt = ra_r + RW'(1);
        if (last_ra) begin
          for (int r = 0; r < MAX_RES; r++) begin
            if (32'(r) < 32'(nr)) avail_nxt[r] = avail_r[r] + req_r[r];
            req_nxt[r] = '0;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = bsc_pkg::ST_DENIED;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start_chk) begin
      for (int r = 0; r < MAX_RES; r++) begin
        work_nxt[r] = (32'(r) < 32'(nr)) ? avail_r[r] : '0;
      end
      fin_nxt      = '0;
      progress_nxt = 1'b0;
      p_nxt        = '0;
      state_nxt    = S_PSEL;
    end

    // Advance to the next process; a pass without progress ends the check
    if (adv) begin
      if (PW'(p_r) == (np - PW'(1))) begin
        if (progress_nxt) begin
          p_nxt        = '0;
          progress_nxt = 1'b0;
          state_nxt    = S_PSEL;
        end else if ((fin_nxt & proc_mask) == proc_mask) begin
          out_valid_nxt = 1'b1;
          if (req_mode_r) begin
            out_status_nxt = bsc_pkg::ST_GRANTED;
            for (int r = 0; r < MAX_RES; r++) req_nxt[r] = '0;
          end else begin
            out_status_nxt = bsc_pkg::ST_SAFE;
          end
          state_nxt = S_IDLE;
        end else if (req_mode_r) begin
          ra_nxt    = '0;
          state_nxt = S_ROLL;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bsc_pkg::ST_UNSAFE;
          state_nxt      = S_IDLE;
        end
      end else begin
        p_nxt     = p_r + PIW'(1);
        state_nxt = S_PSEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      proc_count_r <= 5'd16;
      res_count_r  <= 4'd8;
      pend_r       <= 1'b0;
      flag_r       <= 1'b0;
      progress_r   <= 1'b0;
      req_mode_r   <= 1'b0;
      fin_r        <= '0;
      out_valid_r  <= 1'b0;
      p_r          <= '0;
      ra_r         <= '0;
      rd_r         <= '0;
      for (int r = 0; r < MAX_RES; r++) begin
        work_r[r]  <= '0;
        avail_r[r] <= '0;
        req_r[r]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      flag_r      <= flag_nxt;
      progress_r  <= progress_nxt;
      req_mode_r  <= req_mode_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      p_r         <= p_nxt;
      ra_r        <= ra_nxt;
      rd_r        <= rd_nxt;
      work_r      <= work_nxt;
      avail_r     <= avail_nxt;
      req_r       <= req_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bsc_pkg::CFG_PROC_COUNT: proc_count_r <= cfg_data[4:0];
          bsc_pkg::CFG_RES_COUNT:  res_count_r  <= cfg_data[3:0];
          default:                 proc_count_r <= proc_count_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    reqp_r       <= reqp_nxt;
    row_r        <= row_nxt;
    keep_r       <= keep_nxt;
    out_status_r <= out_status_nxt;
    out_echo_r   <= out_echo_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_proc_echo = out_echo_r;

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_FIT || state_r == S_RCHK))
    else $error("read pending outside a table scan");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result issued while sequencer still active");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY || state_r == S_ROLL || state_r == S_ADD) |-> (ra_r < nr))
    else $error("row index beyond resources in use");

  a_grant_restores: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == bsc_pkg::ST_DENIED) |-> $past(state_r == S_ROLL))
    else $error("denial without roll-back");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banker's safety check engine. A scoreboard class
// keeps its own copy of the tables and counts, predicts the status of every
// accepted command that gives an answer and compares each result strobe in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int NP = 16;
  localparam int NR = 8;
  localparam int WATCHDOG = 40000;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] proc_id;
  } answer_t;

  class bank_scoreboard;
    logic [4:0] n_procs;
    logic [3:0] n_res;
    logic [7:0] alloc [NP][NR];
    logic [7:0] maxv [NP][NR];
    logic [7:0] avail [NR];
    logic [7:0] req [NR];
    answer_t pending [$];
    int errors;

    function new();
      n_procs = 5'd16;
      n_res = 4'd8;
      foreach (alloc[p, r]) begin
        alloc[p][r] = '0;
        maxv[p][r] = '0;
      end
      foreach (avail[r]) begin
        avail[r] = '0;
        req[r] = '0;
      end
      errors = 0;
    endfunction

    function int procs_used();
      if (n_procs == 0) return 1;
      return (n_procs > NP) ? NP : int'(n_procs);
    endfunction

    function int res_used();
      if (n_res == 0) return 1;
      return (n_res > NR) ? NR : int'(n_res);
    endfunction

    function int need(int p, int r);
      return (maxv[p][r] > alloc[p][r]) ? int'(maxv[p][r] - alloc[p][r]) : 0;
    endfunction

    function bit is_safe();
      int work [NR];
      bit done [NP];
      bit moved;
      bit fits;
      int np;
      int nr;
      np = procs_used();
      nr = res_used();
      for (int r = 0; r < NR; r++) work[r] = int'(avail[r]);
      for (int p = 0; p < NP; p++) done[p] = 0;
      moved = 1;
      while (moved) begin
        moved = 0;
        for (int p = 0; p < np; p++) begin
          if (!done[p]) begin
            fits = 1;
            for (int r = 0; r < nr; r++) if (need(p, r) > work[r]) fits = 0;
            if (fits) begin
              for (int r = 0; r < nr; r++) work[r] = work[r] + int'(alloc[p][r]);
              done[p] = 1;
              moved = 1;
            end
          end
        end
      end
      for (int p = 0; p < np; p++) if (!done[p]) return 0;
      return 1;
    endfunction

    function logic [2:0] grant(int p);
      int nr;
      nr = res_used();
      if (p >= procs_used()) return bsc_pkg::ST_OVER_NEED;
      for (int r = 0; r < nr; r++)
        if (int'(req[r]) > need(p, r)) return bsc_pkg::ST_OVER_NEED;
      for (int r = 0; r < nr; r++) if (req[r] > avail[r]) return bsc_pkg::ST_OVER_AVL;
      for (int r = 0; r < nr; r++) begin
        avail[r] -= req[r];
        alloc[p][r] += req[r];
      end
      if (is_safe()) return bsc_pkg::ST_GRANTED;
      // roll the tentative grant back
      for (int r = 0; r < nr; r++) begin
        avail[r] += req[r];
        alloc[p][r] -= req[r];
      end
      return bsc_pkg::ST_DENIED;
    endfunction

    function void note_input(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                             logic [7:0] amt, logic last);
      answer_t a;
      a.proc_id = p;
      case (op)
        bsc_pkg::OP_WR_ALLOC: begin
          alloc[p][r] = amt;
          a.status = bsc_pkg::ST_WRITTEN;
        end
        bsc_pkg::OP_WR_MAX: begin
          maxv[p][r] = amt;
          a.status = bsc_pkg::ST_WRITTEN;
        end
        bsc_pkg::OP_WR_AVAIL: begin
          avail[r] = amt;
          a.status = bsc_pkg::ST_WRITTEN;
        end
        bsc_pkg::OP_CHECK: a.status = is_safe() ? bsc_pkg::ST_SAFE : bsc_pkg::ST_UNSAFE;
        bsc_pkg::OP_REQ_ELEM: begin
          req[r] = amt;
          if (!last) return;
          a.status = grant(int'(p));
          foreach (req[i]) req[i] = '0;
        end
        default: return;
      endcase
      pending.push_back(a);
    endfunction

    function void check_result(logic [2:0] st, logic [3:0] p);
      answer_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d proc=%0d", st, p);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || p !== e.proc_id) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status exp %0d got %0d, proc exp %0d got %0d",
                   e.status, st, e.proc_id, p);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_proc_index = '0;
  logic [2:0] in_res_index = '0;
  logic [7:0] in_amount = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic [2:0] out_status;
  logic [3:0] out_proc_echo;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bank_scoreboard sb = new();
  bit quiet_stretch;
  int idle_cycles;

  always #5 clk = ~clk;

  bankers_safety_check dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_proc_echo);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // start stays high after a transfer; idling or draining drops it
  task automatic send(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                      logic [7:0] amt, logic last);
    while (!quiet_stretch && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_proc_index <= p;
    in_res_index <= r;
    in_amount <= amt;
    in_last_element <= last;
    do @(posedge clk); while (busy);
    sb.note_input(op, p, r, amt, last);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_counts(logic [4:0] np, logic [3:0] nr);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= bsc_pkg::CFG_PROC_COUNT;
    cfg_data <= np;
    @(posedge clk);
    cfg_index <= bsc_pkg::CFG_RES_COUNT;
    cfg_data <= {1'b0, nr};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.n_procs = np;
    sb.n_res = nr;
  endtask

  // well-formed scenario: random tables then a run of requests, each followed by a check
  task automatic scenario(int np, int nr);
    for (int r = 0; r < nr; r++)
      send(bsc_pkg::OP_WR_AVAIL, 4'($urandom), 3'(r), 8'($urandom_range(12)), 1'b0);
    for (int p = 0; p < np; p++)
      for (int r = 0; r < nr; r++) begin
        send(bsc_pkg::OP_WR_MAX, 4'(p), 3'(r), 8'($urandom_range(10)), 1'($urandom));
        send(bsc_pkg::OP_WR_ALLOC, 4'(p), 3'(r), 8'($urandom_range(6)), 1'($urandom));
      end
    for (int k = 0; k < 6; k++) begin
      int p;
      p = int'($urandom_range(np - 1));
      for (int r = 0; r < nr; r++)
        send(bsc_pkg::OP_REQ_ELEM, 4'(p), 3'(r), 8'($urandom_range(4)), r == nr - 1);
      send(bsc_pkg::OP_CHECK, 4'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    quiet_stretch = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: check of empty tables, extremes, every opcode
    send(bsc_pkg::OP_CHECK, 4'd15, 3'd7, 8'd255, 1'b1);
    send(bsc_pkg::OP_WR_MAX, 4'd15, 3'd7, 8'd255, 1'b0);
    send(bsc_pkg::OP_WR_ALLOC, 4'd15, 3'd7, 8'd0, 1'b1);
    send(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 8'd0, 1'b0);
    send(bsc_pkg::OP_WR_AVAIL, 4'd3, 3'd7, 8'd255, 1'b0);
    send(bsc_pkg::OP_REQ_ELEM, 4'd15, 3'd7, 8'd255, 1'b0);
    send(bsc_pkg::OP_REQ_ELEM, 4'd15, 3'd0, 8'd0, 1'b1);
    send(bsc_pkg::OP_REQ_ELEM, 4'd2, 3'd0, 8'd1, 1'b1);
    send(3'd5, 4'd1, 3'd1, 8'd1, 1'b1);
    send(3'd7, 4'd1, 3'd1, 8'd1, 1'b0);
    send(bsc_pkg::OP_WR_MAX, 4'd0, 3'd0, 8'd3, 1'b0);
    send(bsc_pkg::OP_WR_AVAIL, 4'd0, 3'd0, 8'd2, 1'b0);
    send(bsc_pkg::OP_REQ_ELEM, 4'd0, 3'd0, 8'd3, 1'b1);
    send(bsc_pkg::OP_REQ_ELEM, 4'd0, 3'd0, 8'd2, 1'b1);
    send(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 8'd0, 1'b0);
    // request for a process beyond the count in use, and out-of-range counts
    set_counts(5'd2, 4'd1);
    send(bsc_pkg::OP_REQ_ELEM, 4'd5, 3'd0, 8'd0, 1'b1);
    send(bsc_pkg::OP_REQ_ELEM, 4'd1, 3'd3, 8'd9, 1'b0);
    send(bsc_pkg::OP_REQ_ELEM, 4'd1, 3'd0, 8'd0, 1'b1);
    set_counts(5'd0, 4'd0);
    send(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 8'd0, 1'b0);
    set_counts(5'd31, 4'd15);
    send(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 8'd0, 1'b0);
    // hold off until everything has come back
    drain();
    set_counts(5'd3, 4'd2);
    quiet_stretch = 1;
    scenario(3, 2);
    quiet_stretch = 0;
    set_counts(5'd4, 4'd3);
    scenario(4, 3);
    set_counts(5'd1, 4'd8);
    scenario(1, 8);
    set_counts(5'd16, 4'd1);
    scenario(5, 1);
    // noise
    for (int k = 0; k < 80; k++)
      send(3'($urandom_range(7)), 4'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
    set_counts(5'd16, 4'd8);
    send(bsc_pkg::OP_CHECK, 4'd9, 3'd2, 8'd0, 1'b0);
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
